// ----- src/aes128_pkg.sv -----
// Shared types, codes and GF(2^8) helpers for the AES-128 block encryptor.
package aes128_pkg;

  localparam int unsigned RoundCountDef = 10;

  // Command codes on the input channel
  typedef enum logic [1:0] {
    CmdSubLoad = 2'd0,
    CmdKeyLoad = 2'd1,
    CmdText    = 2'd2,
    CmdNone    = 2'd3
  } cmd_e;

  // Controller states
  typedef enum logic [1:0] {
    StIdle = 2'd0,
    StRun  = 2'd1,
    StOut0 = 2'd2,
    StOut1 = 2'd3
  } state_e;

  // Text half indexes
  localparam logic [7:0] HalfFirst  = 8'd0;
  localparam logic [7:0] HalfSecond = 8'd1;

  // Datapath commands from the controller
  typedef struct packed {
    logic       sub_we;
    logic       key_we;
    logic       pend_we;
    logic       load_blk;
    logic       key_cap_hi;
    logic       key_cap_lo;
    logic [1:0] sb_col;
    logic       sb_cap;
    logic [1:0] cap_col;
    logic       fin;
    logic       first_rnd;
    logic       last_rnd;
    logic       out_hi;
  } dp_cmd_t;

  localparam logic [7:0] Poly = 8'h1B;

  // Multiply by two in GF(2^8)
  function automatic logic [7:0] xtime(input logic [7:0] a);
    logic [7:0] d;
    d = {a[6:0], 1'b0};
    if (a[7]) begin
      d = d ^ Poly;
    end
    return d;
  endfunction

  // MixColumns on one column, row 0 in the top byte
  function automatic logic [31:0] mix_col(input logic [31:0] x);
    logic [7:0] a0, a1, a2, a3, d0, d1, d2, d3;
    a0 = x[31:24];
    a1 = x[23:16];
    a2 = x[15:8];
    a3 = x[7:0];
    d0 = xtime(a0);
    d1 = xtime(a1);
    d2 = xtime(a2);
    d3 = xtime(a3);
    return {d0 ^ d1 ^ a1 ^ a2 ^ a3,
            a0 ^ d1 ^ d2 ^ a2 ^ a3,
            a0 ^ a1 ^ d2 ^ d3 ^ a3,
            d0 ^ a0 ^ a1 ^ a2 ^ d3};
  endfunction

endpackage

// ----- src/aes128_if.sv -----
// Valid/ready channel interfaces for the input commands and the ciphertext results.
interface aes128_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  cmd;
  logic [7:0]  index;
  logic [63:0] value;

  modport source (output valid, output cmd, output index, output value, input ready);
  modport sink (input valid, input cmd, input index, input value, output ready);
endinterface

interface aes128_out_if;
  logic        valid;
  logic        ready;
  logic [63:0] cipher_half;
  logic        half_number;
  logic        final_half;

  modport source (output valid, output cipher_half, output half_number, output final_half,
                  input ready);
  modport sink (input valid, input cipher_half, input half_number, input final_half,
                output ready);
endinterface

// ----- src/aes128_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
module aes128_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem [Depth];

  // Write and registered read
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_o <= mem[raddr_i];
  end

endmodule

// ----- src/aes128_ctrl.sv -----
// Controller: command decode, round sequencing and result handshake.
module aes128_ctrl #(
  parameter int unsigned RoundCount = aes128_pkg::RoundCountDef,
  localparam int unsigned KeyWords  = 2 * (RoundCount + 1),
  localparam int unsigned RndW      = $clog2(RoundCount + 1),
  localparam int unsigned KeyAw     = RndW + 1
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  input  logic [1:0]          in_cmd_i,
  input  logic [7:0]          in_index_i,
  output logic                in_ready_o,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output logic                out_last_o,
  output logic [KeyAw-1:0]    key_raddr_o,
  output aes128_pkg::dp_cmd_t cmd_o
);

  aes128_pkg::state_e state_q, state_d;
  logic [2:0]      step_q, step_d;
  logic [RndW-1:0] rnd_q, rnd_d;
  logic            have_q, have_d;
  logic            acc;
  logic            start;
  logic            rnd_done;

  assign acc      = in_valid_i && in_ready_o;
  assign start    = acc && (in_cmd_i == aes128_pkg::CmdText) &&
                    (in_index_i == aes128_pkg::HalfSecond) && have_q;
  assign rnd_done = (step_q == 3'd5);

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      aes128_pkg::StIdle: if (start) state_d = aes128_pkg::StRun;
      aes128_pkg::StRun: begin
        if (rnd_done && (rnd_q == RndW'(RoundCount))) state_d = aes128_pkg::StOut0;
      end
      aes128_pkg::StOut0: if (out_ready_i) state_d = aes128_pkg::StOut1;
      aes128_pkg::StOut1: if (out_ready_i) state_d = aes128_pkg::StIdle;
      default: state_d = aes128_pkg::StIdle;
    endcase
  end

  // Advance step and round counters, track the stored first half
  always_comb begin
    step_d = step_q;
    rnd_d  = rnd_q;
    have_d = have_q;
    if (start) begin
      step_d = 3'd0;
      rnd_d  = '0;
      have_d = 1'b0;
    end else if (state_q == aes128_pkg::StRun) begin
      if (rnd_done) begin
        step_d = 3'd0;
        rnd_d  = rnd_q + RndW'(1);
      end else begin
        step_d = step_q + 3'd1;
      end
    end
    if (acc && (in_cmd_i == aes128_pkg::CmdText) && (in_index_i == aes128_pkg::HalfFirst)) begin
      have_d = 1'b1;
    end
  end

  // Outputs and datapath commands
  always_comb begin
    in_ready_o        = (state_q == aes128_pkg::StIdle);
    out_valid_o       = (state_q == aes128_pkg::StOut0) || (state_q == aes128_pkg::StOut1);
    out_last_o        = (state_q == aes128_pkg::StOut1);
    key_raddr_o       = {rnd_q, step_q[0]};
    cmd_o             = '0;
    cmd_o.sub_we      = acc && (in_cmd_i == aes128_pkg::CmdSubLoad);
    cmd_o.key_we      = acc && (in_cmd_i == aes128_pkg::CmdKeyLoad) &&
                        (in_index_i < 8'(KeyWords));
    cmd_o.pend_we     = acc && (in_cmd_i == aes128_pkg::CmdText) &&
                        (in_index_i == aes128_pkg::HalfFirst);
    cmd_o.load_blk    = start;
    cmd_o.key_cap_hi  = (step_q == 3'd1);
    cmd_o.key_cap_lo  = (step_q == 3'd2);
    cmd_o.sb_col      = step_q[1:0];
    cmd_o.sb_cap      = (step_q >= 3'd1) && (step_q <= 3'd4);
    cmd_o.cap_col     = step_q[1:0] - 2'd1;
    cmd_o.fin         = (state_q == aes128_pkg::StRun) && rnd_done;
    cmd_o.first_rnd   = (rnd_q == '0);
    cmd_o.last_rnd    = (rnd_q == RndW'(RoundCount));
    cmd_o.out_hi      = (state_q == aes128_pkg::StOut1);
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= aes128_pkg::StIdle;
      step_q  <= 3'd0;
      rnd_q   <= '0;
      have_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      step_q  <= step_d;
      rnd_q   <= rnd_d;
      have_q  <= have_d;
    end
  end

endmodule

// ----- src/aes128_dp.sv -----
// Datapath: table and key memories, state register, round function.
module aes128_dp #(
  parameter int unsigned RoundCount = aes128_pkg::RoundCountDef,
  localparam int unsigned KeyWords  = 2 * (RoundCount + 1),
  localparam int unsigned KeyAw     = $clog2(RoundCount + 1) + 1
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  aes128_pkg::dp_cmd_t cmd_i,
  input  logic [KeyAw-1:0]    key_raddr_i,
  input  logic [7:0]          in_index_i,
  input  logic [63:0]         in_value_i,
  output logic [63:0]         cipher_o
);

  logic [63:0]  pend_q;
  logic [127:0] st_q, st_d;
  logic [127:0] tmp_q;
  logic [63:0]  khi_q, klo_q;
  logic [63:0]  key_rdata;
  logic [7:0]   sb_raddr [4];
  logic [7:0]   sb_rdata [4];
  logic [127:0] rk;
  logic [127:0] mixed;

  // Four copies of the substitution table, one per row
  for (genvar r = 0; r < 4; r++) begin : g_sub
    logic [1:0] col;
    logic [3:0] idx;
    assign col          = cmd_i.sb_col + 2'(r);
    assign idx          = {col, 2'(r)};
    assign sb_raddr[r]  = st_q[{~idx, 3'b000} +: 8];

    aes128_ram #(.Width(8), .Depth(256)) u_sub (
      .clk_i  (clk_i),
      .we_i   (cmd_i.sub_we),
      .waddr_i(in_index_i),
      .wdata_i(in_value_i[7:0]),
      .raddr_i(sb_raddr[r]),
      .rdata_o(sb_rdata[r])
    );
  end

  // Round key words
  aes128_ram #(.Width(64), .Depth(KeyWords)) u_key (
    .clk_i  (clk_i),
    .we_i   (cmd_i.key_we),
    .waddr_i(in_index_i[KeyAw-1:0]),
    .wdata_i(in_value_i),
    .raddr_i(key_raddr_i),
    .rdata_o(key_rdata)
  );

  // Capture substituted bytes in shifted position, and key words
  always_ff @(posedge clk_i) begin
    if (cmd_i.sb_cap) begin
      for (int r = 0; r < 4; r++) begin
        tmp_q[{~{cmd_i.cap_col, 2'(r)}, 3'b000} +: 8] <= sb_rdata[r];
      end
    end
    if (cmd_i.key_cap_hi) begin
      khi_q <= key_rdata;
    end
    if (cmd_i.key_cap_lo) begin
      klo_q <= key_rdata;
    end
  end

  // Mix all four columns
  always_comb begin
    for (int c = 0; c < 4; c++) begin
      mixed[32*c +: 32] = aes128_pkg::mix_col(tmp_q[32*c +: 32]);
    end
  end

  assign rk = {khi_q, klo_q};

  // Finish a round or load a new block
  always_comb begin
    st_d = st_q;
    if (cmd_i.load_blk) begin
      st_d = {pend_q, in_value_i};
    end else if (cmd_i.fin) begin
      if (cmd_i.first_rnd) begin
        st_d = st_q ^ rk;
      end else if (cmd_i.last_rnd) begin
        st_d = tmp_q ^ rk;
      end else begin
        st_d = mixed ^ rk;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    st_q <= st_d;
  end

  // Hold the first plaintext half
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q <= '0;
    end else if (cmd_i.pend_we) begin
      pend_q <= in_value_i;
    end
  end

  assign cipher_o = cmd_i.out_hi ? st_q[63:0] : st_q[127:64];

endmodule

// ----- src/aes128_block_encrypt.sv -----
// Top level of the AES-128 block encryptor with loaded key schedule and S-box.
// The block takes load commands and plaintext halves on in_i and returns two
// ciphertext halves on out_o. Substitution bytes and round key words are loaded
// beforehand with their commands; key words at an index past the schedule are
// dropped. A second plaintext half after a first one starts an encryption:
// every round makes two key word reads and four column lookups into four
// copies of the substitution RAM, then the mix and key add, and a block runs
// RoundCount + 1 rounds in the round unit before the two result transfers.
// No input is taken from the start of a block until its second ciphertext
// half has been transferred.
module aes128_block_encrypt #(
  parameter int unsigned RoundCount = aes128_pkg::RoundCountDef
) (
  input logic        clk_i,
  input logic        rst_ni,
  aes128_in_if.sink    in_i,
  aes128_out_if.source out_o
);

  localparam int unsigned KeyAw = $clog2(RoundCount + 1) + 1;

  aes128_pkg::dp_cmd_t dp_cmd;
  logic [KeyAw-1:0]    key_raddr;
  logic                out_last;

  aes128_ctrl #(.RoundCount(RoundCount)) u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_i.valid),
    .in_cmd_i   (in_i.cmd),
    .in_index_i (in_i.index),
    .in_ready_o (in_i.ready),
    .out_valid_o(out_o.valid),
    .out_ready_i(out_o.ready),
    .out_last_o (out_last),
    .key_raddr_o(key_raddr),
    .cmd_o      (dp_cmd)
  );

  aes128_dp #(.RoundCount(RoundCount)) u_dp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_i      (dp_cmd),
    .key_raddr_i(key_raddr),
    .in_index_i (in_i.index),
    .in_value_i (in_i.value),
    .cipher_o   (out_o.cipher_half)
  );

  // Second half is also the final one
  assign out_o.half_number = out_last;
  assign out_o.final_half  = out_last;

endmodule

// ----- tb/testbench.sv -----
// Self-checking testbench for the AES-128 block encryptor with loaded tables.
module testbench;

  localparam int unsigned KeyWords = 2 * (aes128_pkg::RoundCountDef + 1);
  localparam int unsigned RandItems = 1000;

  typedef struct {
    logic [63:0] half;
    logic        num;
    logic        fin;
  } cipher_res_t;

  typedef struct {
    aes128_pkg::cmd_e cmd;
    logic [7:0]       index;
    logic [63:0]      value;
    int               n_res;   // results this transfer causes
  } stim_row_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  aes128_in_if  in_if ();
  aes128_out_if out_if ();

  aes128_block_encrypt i_dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .in_i  (in_if.sink),
    .out_o (out_if.source)
  );

  // Shadow of the block state
  logic [7:0]  sbox_q [256];
  logic [63:0] rkey_q [KeyWords];
  logic [63:0] pend_q;
  logic        have_q;
  cipher_res_t cipher_fifo[$];
  int          err_cnt;
  int          phase;   // 0 none, 1 sender idles, 2 receiver stalls, 3 both

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // Bound the run
  initial begin
    #4000000;
    $display("testbench: errors");
    $finish;
  end

  function automatic logic [7:0] gmul2(input logic [7:0] a);
    return {a[6:0], 1'b0} ^ (a[7] ? 8'h1B : 8'h00);
  endfunction

  // Encrypt one 128-bit block with the shadow tables
  function automatic logic [127:0] aes_encrypt(input logic [127:0] blk);
    logic [7:0] s [16];
    logic [7:0] t [16];
    logic [7:0] a0, a1, a2, a3;
    logic [127:0] rk;
    logic [127:0] res;
    for (int i = 0; i < 16; i++) s[i] = blk[127 - 8 * i -: 8];
    for (int r = 0; r <= aes128_pkg::RoundCountDef; r++) begin
      if (r > 0) begin
        // substitute and shift rows
        for (int c = 0; c < 4; c++)
          for (int w = 0; w < 4; w++) t[4 * c + w] = sbox_q[s[4 * ((c + w) % 4) + w]];
        for (int i = 0; i < 16; i++) s[i] = t[i];
        if (r < aes128_pkg::RoundCountDef) begin
          for (int c = 0; c < 4; c++) begin
            a0 = s[4 * c]; a1 = s[4 * c + 1]; a2 = s[4 * c + 2]; a3 = s[4 * c + 3];
            s[4 * c]     = gmul2(a0) ^ gmul2(a1) ^ a1 ^ a2 ^ a3;
            s[4 * c + 1] = a0 ^ gmul2(a1) ^ gmul2(a2) ^ a2 ^ a3;
            s[4 * c + 2] = a0 ^ a1 ^ gmul2(a2) ^ gmul2(a3) ^ a3;
            s[4 * c + 3] = gmul2(a0) ^ a0 ^ a1 ^ a2 ^ gmul2(a3);
          end
        end
      end
      rk = {rkey_q[2 * r], rkey_q[2 * r + 1]};
      for (int i = 0; i < 16; i++) s[i] = s[i] ^ rk[127 - 8 * i -: 8];
    end
    for (int i = 0; i < 16; i++) res[127 - 8 * i -: 8] = s[i];
    return res;
  endfunction

  // Apply one accepted transfer to the shadow state, queue its ciphertext
  function automatic void predict_transfer(input aes128_pkg::cmd_e cmd,
                                           input logic [7:0] idx,
                                           input logic [63:0] val);
    logic [127:0] ct;
    case (cmd)
      aes128_pkg::CmdSubLoad: sbox_q[idx] = val[7:0];
      aes128_pkg::CmdKeyLoad: if (idx < KeyWords) rkey_q[idx] = val;
      aes128_pkg::CmdText: begin
        if (idx == aes128_pkg::HalfFirst) begin
          pend_q = val;
          have_q = 1'b1;
        end else if (idx == aes128_pkg::HalfSecond && have_q) begin
          ct = aes_encrypt({pend_q, val});
          cipher_fifo.push_back('{ct[127:64], 1'b0, 1'b0});
          cipher_fifo.push_back('{ct[63:0], 1'b1, 1'b1});
          have_q = 1'b0;
        end
      end
      default: ;
    endcase
  endfunction

  // Track accepted inputs
  always @(posedge clk_i) begin
    if (rst_ni && in_if.valid && in_if.ready)
      predict_transfer(aes128_pkg::cmd_e'(in_if.cmd), in_if.index, in_if.value);
  end

  // Check accepted results
  always @(posedge clk_i) begin
    cipher_res_t want;
    if (rst_ni && out_if.valid && out_if.ready) begin
      if (cipher_fifo.size() == 0) begin
        $error("unexpected result %h", out_if.cipher_half);
        err_cnt++;
      end else begin
        want = cipher_fifo.pop_front();
        if (out_if.cipher_half !== want.half) begin
          $error("cipher_half: expected %h, got %h", want.half, out_if.cipher_half);
          err_cnt++;
        end
        if (out_if.half_number !== want.num) begin
          $error("half_number: expected %0d, got %0d", want.num, out_if.half_number);
          err_cnt++;
        end
        if (out_if.final_half !== want.fin) begin
          $error("final_half: expected %0d, got %0d", want.fin, out_if.final_half);
          err_cnt++;
        end
      end
    end
  end

  // Stall the result channel per phase
  always @(negedge clk_i) begin
    out_if.ready <= !((phase == 2 || phase == 3) && $urandom_range(99) < 47);
  end

  // Drive one transfer, idling per phase, and hold until accepted
  task automatic send(input aes128_pkg::cmd_e cmd, input logic [7:0] idx,
                      input logic [63:0] val);
    int pct;
    pct = (phase == 1) ? 47 : (phase == 3) ? 38 : 0;
    @(negedge clk_i);
    while ($urandom_range(99) < pct) begin
      in_if.valid = 1'b0;
      @(negedge clk_i);
    end
    in_if.valid = 1'b1;
    in_if.cmd   = cmd;
    in_if.index = idx;
    in_if.value = val;
    do @(posedge clk_i); while (!in_if.ready);
    @(negedge clk_i);
    in_if.valid = 1'b0;
  endtask

  function automatic logic [63:0] rand64();
    return {$urandom(), $urandom()};
  endfunction

  stim_row_t dir_rows [17] = '{
    '{aes128_pkg::CmdKeyLoad, 8'd22,  64'hFFFF_FFFF_FFFF_FFFF, 0},  // key index past schedule
    '{aes128_pkg::CmdKeyLoad, 8'd255, 64'h0,                   0},
    '{aes128_pkg::CmdText,    aes128_pkg::HalfSecond, 64'h1234_5678_9ABC_DEF0, 0},  // no first
    '{aes128_pkg::CmdNone,    8'd0,   64'hFFFF_FFFF_FFFF_FFFF, 0},
    '{aes128_pkg::CmdText,    8'd2,   64'h0,                   0},  // half index above one
    '{aes128_pkg::CmdText,    8'd255, 64'hFFFF_FFFF_FFFF_FFFF, 0},
    '{aes128_pkg::CmdText,    aes128_pkg::HalfFirst,  64'hFFFF_FFFF_FFFF_FFFF, 0},
    '{aes128_pkg::CmdText,    aes128_pkg::HalfFirst,  64'h0,                   0},  // replaces
    '{aes128_pkg::CmdText,    aes128_pkg::HalfSecond, 64'h0,                   2},
    '{aes128_pkg::CmdText,    aes128_pkg::HalfFirst,  64'hFFFF_FFFF_FFFF_FFFF, 0},
    '{aes128_pkg::CmdText,    aes128_pkg::HalfSecond, 64'hFFFF_FFFF_FFFF_FFFF, 2},
    '{aes128_pkg::CmdText,    aes128_pkg::HalfSecond, 64'hFFFF_FFFF_FFFF_FFFF, 0},  // cleared
    '{aes128_pkg::CmdSubLoad, 8'd0,   64'hFFFF_FFFF_FFFF_FF63, 0},  // only low byte stored
    '{aes128_pkg::CmdKeyLoad, 8'd21,  64'hFFFF_FFFF_FFFF_FFFF, 0},
    '{aes128_pkg::CmdKeyLoad, 8'd0,   64'h0,                   0},
    '{aes128_pkg::CmdText,    aes128_pkg::HalfFirst,  64'h0011_2233_4455_6677, 0},
    '{aes128_pkg::CmdText,    aes128_pkg::HalfSecond, 64'h8899_AABB_CCDD_EEFF, 2}
  };

  initial begin
    int before_n;
    int sent;
    int pick;
    err_cnt = 0;
    phase = 0;
    have_q = 1'b0;
    pend_q = '0;
    in_if.valid = 1'b0;
    in_if.cmd   = aes128_pkg::CmdNone;
    in_if.index = '0;
    in_if.value = '0;
    out_if.ready = 1'b1;
    repeat (12) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // fill both tables before any text
    for (int i = 0; i < 256; i++) send(aes128_pkg::CmdSubLoad, i[7:0], rand64());
    for (int i = 0; i < KeyWords; i++) send(aes128_pkg::CmdKeyLoad, i[7:0], rand64());

    // directed rows, each started with no result outstanding
    foreach (dir_rows[r]) begin
      while (cipher_fifo.size() != 0) @(posedge clk_i);
      before_n = cipher_fifo.size();
      send(dir_rows[r].cmd, dir_rows[r].index, dir_rows[r].value);
      @(posedge clk_i);
      if (cipher_fifo.size() != before_n + dir_rows[r].n_res) begin
        $error("row %0d results: expected %0d, got %0d", r, dir_rows[r].n_res,
               cipher_fifo.size() - before_n);
        err_cnt++;
      end
    end

    // random mix, mostly full blocks
    sent = 0;
    while (sent < RandItems) begin
      phase = (sent * 4) / RandItems;
      pick = $urandom_range(99);
      if (pick < 70) begin
        send(aes128_pkg::CmdText, aes128_pkg::HalfFirst, rand64());
        if ($urandom_range(9) == 0) send(aes128_pkg::CmdText, aes128_pkg::HalfFirst, rand64());
        send(aes128_pkg::CmdText, aes128_pkg::HalfSecond, rand64());
        sent += 2;
      end else if (pick < 78) begin
        send(aes128_pkg::CmdSubLoad, 8'($urandom_range(255)), rand64());
        sent++;
      end else if (pick < 86) begin
        send(aes128_pkg::CmdKeyLoad, 8'($urandom_range(255)), rand64());
        sent++;
      end else if (pick < 93) begin
        send(aes128_pkg::CmdText, 8'($urandom_range(255)), rand64());
        sent++;
      end else begin
        send(aes128_pkg::CmdNone, 8'($urandom_range(255)), rand64());
        sent++;
      end
    end

    // drain
    phase = 0;
    while (cipher_fifo.size() != 0) @(posedge clk_i);
    repeat (100) @(posedge clk_i);
    if (err_cnt == 0) begin
      $display("testbench: clean");
    end else begin
      $display("testbench: errors");
    end
    $finish;
  end

endmodule
